// ===== hw/rtl/rsnh_pkg.sv =====
`default_nettype none
package rsnh_pkg;

    // Widths of the fixed-point datapath.
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int COORD_W = 32;
    localparam int DIR_W = 18;
    localparam int RAD_W = 31;
    localparam int DIST_W = 31;
    localparam int VMAG_W = 32;
    localparam int PROD_W = 64;
    localparam int H_W = 53;
    localparam int HSPLIT = 26;
    localparam int Q_W = 106;
    localparam int ROOT_W = 53;
    localparam int REM_W = 56;
    localparam int T_W = 55;
    localparam int CNT_W = 6;
    localparam int MUL_STEPS = 10;
    localparam int SQRT_STEPS = ROOT_W;
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIG_X,
        CFG_ORIG_Y,
        CFG_ORIG_Z,
        CFG_DIR_X,
        CFG_DIR_Y,
        CFG_DIR_Z
    } t_cfg_idx;

    // Product select, issued in this order by the controller's counter.
    typedef enum logic [3:0] {
        MS_DX,
        MS_DY,
        MS_DZ,
        MS_VX,
        MS_VY,
        MS_VZ,
        MS_RR,
        MS_HLL,
        MS_HHL,
        MS_HHH
    } t_mul_sel;

    typedef enum logic [2:0] {
        ACC_NONE,
        ACC_H,
        ACC_Q_SUB32,
        ACC_Q_ADD32,
        ACC_Q_ADD0,
        ACC_Q_ADD27,
        ACC_Q_ADD52
    } t_acc_op;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     check;
        logic     sqrt_step;
        logic     root;
        logic     update;
    } t_cmd;

    typedef struct packed {
        logic q_neg;
        logic last;
        logic out_busy;
    } t_status;

    // Where each product goes once it leaves the multiplier register.
    function automatic t_acc_op f_acc_of(t_mul_sel sel);
        t_acc_op op;
        unique case (sel)
            MS_DX, MS_DY, MS_DZ: op = ACC_H;
            MS_VX, MS_VY, MS_VZ: op = ACC_Q_SUB32;
            MS_RR:               op = ACC_Q_ADD32;
            MS_HLL:              op = ACC_Q_ADD0;
            MS_HHL:              op = ACC_Q_ADD27;
            MS_HHH:              op = ACC_Q_ADD52;
            default:             op = ACC_NONE;
        endcase
        return op;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/ray_sphere_nearest_hit.sv =====
// Nearest ray-sphere hit. Write the ray origin and a unit direction (signed Q16.16)
// on the configuration channel while the block is idle, then stream spheres in as
// words of center and radius. Each sphere is finished before the next is accepted:
// ten products go one per cycle through a single shared 32 by 32 multiplier, and
// if the quadratic has real roots, the square root of the quarter-discriminant
// is resolved one bit per cycle; a miss skips it. Only the word marked last
// produces a result word: whether any sphere was hit at or ahead of the origin,
// and the nearest such distance, saturated to the largest Q16.16 value. The result
// sits in an output register, so the next sphere is accepted while it waits to be
// taken.
`default_nettype none
module ray_sphere_nearest_hit (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic [rsnh_pkg::COORD_W-1:0]        i_center_x,
    input  wire logic [rsnh_pkg::COORD_W-1:0]        i_center_y,
    input  wire logic [rsnh_pkg::COORD_W-1:0]        i_center_z,
    input  wire logic [rsnh_pkg::RAD_W-1:0]          i_radius,
    input  wire logic                                i_last_sphere,
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic                                     o_hit_found,
    output logic [rsnh_pkg::DIST_W-1:0]              o_nearest_distance,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [rsnh_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [rsnh_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    rsnh_pkg::t_cmd    cmd;
    rsnh_pkg::t_status status;

    // Configuration words are always taken; the user must send them only while idle, as the block does not enforce it.
    assign o_cfg_ready = 1'b1;

    rsnh_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (status),
        .o_ready  (o_ready),
        .o_cmd    (cmd)
    );

    rsnh_datapath u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_cfg_we           (i_cfg_valid),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_center_x         (i_center_x),
        .i_center_y         (i_center_y),
        .i_center_z         (i_center_z),
        .i_radius           (i_radius),
        .i_last_sphere      (i_last_sphere),
        .i_out_ready        (i_ready),
        .o_out_valid        (o_valid),
        .o_hit_found        (o_hit_found),
        .o_nearest_distance (o_nearest_distance)
    );

    // An accepted sphere always keeps the block busy in the following cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("block ready right after accepting a sphere");

    // A miss result always reports a zero distance.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hit_found) |-> (o_nearest_distance == '0))
        else $error("miss result with nonzero distance");

    // A result word only appears after the controller has finished a sphere.
    a_result_needs_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(cmd.update))
        else $error("result word without a completed sphere");

endmodule
`default_nettype wire

// ===== hw/rtl/rsnh_ctrl.sv =====
`default_nettype none
module rsnh_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire rsnh_pkg::t_status i_status,
    output logic                  o_ready,
    output rsnh_pkg::t_cmd        o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_CHECK,
        S_SQRT,
        S_ROOT,
        S_UPDATE
    } t_state;

    t_state r_state, n_state;
    logic [rsnh_pkg::CNT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt;
        o_cmd = '0;
        o_cmd.mul_sel = rsnh_pkg::MS_DX;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = i_valid;
                n_cnt = '0;
                if (i_valid) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                // One product issued per cycle, then a drain step lets the last one reach its accumulator.
                if (r_cnt < rsnh_pkg::CNT_W'(rsnh_pkg::MUL_STEPS)) begin
                    o_cmd.mul_en = 1'b1;
                    o_cmd.mul_sel = rsnh_pkg::t_mul_sel'(r_cnt[3:0]);
                    n_cnt = r_cnt + 1'b1;
                end else begin
                    n_cnt = '0;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_state = i_status.q_neg ? S_UPDATE : S_SQRT;
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == rsnh_pkg::CNT_W'(rsnh_pkg::SQRT_STEPS - 1)) begin
                    n_state = S_ROOT;
                end
            end
            S_ROOT: begin
                o_cmd.root = 1'b1;
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                if (!(i_status.last && i_status.out_busy)) begin
                    o_cmd.update = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt <= '0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/rsnh_datapath.sv =====
`default_nettype none
module rsnh_datapath (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire rsnh_pkg::t_cmd                    i_cmd,
    output rsnh_pkg::t_status                      o_status,
    input  wire logic                              i_cfg_we,
    input  wire logic [rsnh_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [rsnh_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic [rsnh_pkg::COORD_W-1:0]      i_center_x,
    input  wire logic [rsnh_pkg::COORD_W-1:0]      i_center_y,
    input  wire logic [rsnh_pkg::COORD_W-1:0]      i_center_z,
    input  wire logic [rsnh_pkg::RAD_W-1:0]        i_radius,
    input  wire logic                              i_last_sphere,
    input  wire logic                              i_out_ready,
    output logic                                   o_out_valid,
    output logic                                   o_hit_found,
    output logic [rsnh_pkg::DIST_W-1:0]            o_nearest_distance
);

    localparam int CW = rsnh_pkg::COORD_W;
    localparam int DW = rsnh_pkg::DIR_W;
    localparam int VW = rsnh_pkg::VMAG_W;
    localparam int PW = rsnh_pkg::PROD_W;
    localparam int HW = rsnh_pkg::H_W;
    localparam int HS = rsnh_pkg::HSPLIT;
    localparam int QW = rsnh_pkg::Q_W;
    localparam int SW = rsnh_pkg::ROOT_W;
    localparam int RW = rsnh_pkg::REM_W;
    localparam int TW = rsnh_pkg::T_W;
    localparam int XW = rsnh_pkg::DIST_W;

    logic [CW-1:0] r_orig [3];
    logic [DW-1:0] r_dir [3];

    logic [VW-1:0] r_vm [3];
    logic          r_vs [3];
    logic [rsnh_pkg::RAD_W-1:0] r_rad;
    logic          r_last;

    logic [PW-1:0] r_prod;
    logic          r_psign;
    rsnh_pkg::t_acc_op r_pacc;
    logic [HW-1:0] r_h;
    logic [QW-1:0] r_q;
    logic [QW-1:0] r_radicand;
    logic [RW-1:0] r_rem;
    logic [SW-1:0] r_root;
    logic [TW-1:0] r_t;
    logic          r_tvalid;
    logic [XW-1:0] r_best;
    logic          r_have;
    logic          r_out_valid;
    logic          r_out_hit;
    logic [XW-1:0] r_out_dist;

    logic [CW:0]   v_diff [3];
    logic [CW-1:0] centers [3];
    logic [DW-1:0] dir_mag [3];
    logic [HW-1:0] h_mag;
    logic [VW-1:0] mul_a, mul_b;
    logic          mul_sign;
    logic [HW-1:0] h_term;
    logic [RW-1:0] rem_sh, trial;
    logic [TW-1:0] h_ext, s_ext, t_near, t_far;
    logic [TW-17:0] d_shift;
    logic [XW-1:0] dist_sat;
    logic          take, n_have;
    logic [XW-1:0] n_best;

    assign centers[0] = i_center_x;
    assign centers[1] = i_center_y;
    assign centers[2] = i_center_z;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            v_diff[k] = {r_orig[k][CW-1], r_orig[k]} - {centers[k][CW-1], centers[k]};
            dir_mag[k] = r_dir[k][DW-1] ? (-r_dir[k]) : r_dir[k];
        end
    end

    assign h_mag = r_h[HW-1] ? (-r_h) : r_h;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        mul_sign = 1'b0;
        unique case (i_cmd.mul_sel)
            rsnh_pkg::MS_DX: begin
                mul_a = VW'(dir_mag[0]);
                mul_b = r_vm[0];
                mul_sign = r_dir[0][DW-1] ^ r_vs[0];
            end
            rsnh_pkg::MS_DY: begin
                mul_a = VW'(dir_mag[1]);
                mul_b = r_vm[1];
                mul_sign = r_dir[1][DW-1] ^ r_vs[1];
            end
            rsnh_pkg::MS_DZ: begin
                mul_a = VW'(dir_mag[2]);
                mul_b = r_vm[2];
                mul_sign = r_dir[2][DW-1] ^ r_vs[2];
            end
            rsnh_pkg::MS_VX: begin
                mul_a = r_vm[0];
                mul_b = r_vm[0];
            end
            rsnh_pkg::MS_VY: begin
                mul_a = r_vm[1];
                mul_b = r_vm[1];
            end
            rsnh_pkg::MS_VZ: begin
                mul_a = r_vm[2];
                mul_b = r_vm[2];
            end
            rsnh_pkg::MS_RR: begin
                mul_a = VW'(r_rad);
                mul_b = VW'(r_rad);
            end
            rsnh_pkg::MS_HLL: begin
                mul_a = VW'(h_mag[HS-1:0]);
                mul_b = VW'(h_mag[HS-1:0]);
            end
            rsnh_pkg::MS_HHL: begin
                mul_a = VW'(h_mag[2*HS-1:HS]);
                mul_b = VW'(h_mag[HS-1:0]);
            end
            rsnh_pkg::MS_HHH: begin
                mul_a = VW'(h_mag[2*HS-1:HS]);
                mul_b = VW'(h_mag[2*HS-1:HS]);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign h_term = r_psign ? (-HW'(r_prod)) : HW'(r_prod);

    // Restoring square root, one result bit per step.
    assign rem_sh = {r_rem[RW-3:0], r_radicand[QW-1:QW-2]};
    assign trial = RW'({r_root, 2'b01});

    // Near and far roots; the near one wins if it lies at or ahead of the origin.
    assign h_ext = {{(TW-HW){r_h[HW-1]}}, r_h};
    assign s_ext = TW'(r_root);
    assign t_near = -h_ext - s_ext;
    assign t_far = -h_ext + s_ext;

    assign d_shift = r_t[TW-1:16];
    assign dist_sat = (|d_shift[TW-17:XW]) ? rsnh_pkg::DIST_MAX : d_shift[XW-1:0];
    assign take = r_tvalid && (!r_have || (dist_sat < r_best));
    assign n_have = r_have || take;
    assign n_best = take ? dist_sat : r_best;

    assign o_status.q_neg = r_q[QW-1];
    assign o_status.last = r_last;
    assign o_status.out_busy = r_out_valid && !i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_orig[0] <= '0;
            r_orig[1] <= '0;
            r_orig[2] <= '0;
            r_dir[0] <= DW'(65536);
            r_dir[1] <= '0;
            r_dir[2] <= '0;
            r_pacc <= rsnh_pkg::ACC_NONE;
            r_have <= 1'b0;
            r_best <= '0;
            r_out_valid <= 1'b0;
            r_tvalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    rsnh_pkg::CFG_ORIG_X: r_orig[0] <= i_cfg_data;
                    rsnh_pkg::CFG_ORIG_Y: r_orig[1] <= i_cfg_data;
                    rsnh_pkg::CFG_ORIG_Z: r_orig[2] <= i_cfg_data;
                    rsnh_pkg::CFG_DIR_X:  r_dir[0] <= i_cfg_data[DW-1:0];
                    rsnh_pkg::CFG_DIR_Y:  r_dir[1] <= i_cfg_data[DW-1:0];
                    rsnh_pkg::CFG_DIR_Z:  r_dir[2] <= i_cfg_data[DW-1:0];
                    default: ;
                endcase
            end

            if (i_cmd.load) begin
                for (int k = 0; k < 3; k++) begin
                    r_vs[k] <= v_diff[k][CW];
                    r_vm[k] <= v_diff[k][CW] ? VW'(-v_diff[k]) : v_diff[k][VW-1:0];
                end
                r_rad <= i_radius;
                r_last <= i_last_sphere;
                r_h <= '0;
                r_q <= '0;
            end

            r_pacc <= i_cmd.mul_en ? rsnh_pkg::f_acc_of(i_cmd.mul_sel) : rsnh_pkg::ACC_NONE;
            if (i_cmd.mul_en) begin
                r_prod <= PW'(mul_a) * PW'(mul_b);
                r_psign <= mul_sign;
            end

            unique case (r_pacc)
                rsnh_pkg::ACC_H:       r_h <= r_h + h_term;
                rsnh_pkg::ACC_Q_SUB32: r_q <= r_q - (QW'(r_prod) << 32);
                rsnh_pkg::ACC_Q_ADD32: r_q <= r_q + (QW'(r_prod) << 32);
                rsnh_pkg::ACC_Q_ADD0:  r_q <= r_q + QW'(r_prod);
                rsnh_pkg::ACC_Q_ADD27: r_q <= r_q + (QW'(r_prod) << (HS + 1));
                rsnh_pkg::ACC_Q_ADD52: r_q <= r_q + (QW'(r_prod) << (2 * HS));
                default: ;
            endcase

            if (i_cmd.check) begin
                r_tvalid <= 1'b0;
                r_radicand <= r_q;
                r_rem <= '0;
                r_root <= '0;
            end

            if (i_cmd.sqrt_step) begin
                r_radicand <= r_radicand << 2;
                if (rem_sh >= trial) begin
                    r_rem <= rem_sh - trial;
                    r_root <= {r_root[SW-2:0], 1'b1};
                end else begin
                    r_rem <= rem_sh;
                    r_root <= {r_root[SW-2:0], 1'b0};
                end
            end

            if (i_cmd.root) begin
                if (!t_near[TW-1]) begin
                    r_t <= t_near;
                    r_tvalid <= 1'b1;
                end else if (!t_far[TW-1]) begin
                    r_t <= t_far;
                    r_tvalid <= 1'b1;
                end else begin
                    r_tvalid <= 1'b0;
                end
            end

            if (i_cmd.update && r_last) begin
                r_out_valid <= 1'b1;
                r_out_hit <= n_have;
                r_out_dist <= n_have ? n_best : '0;
                r_have <= 1'b0;
                r_best <= '0;
            end else begin
                if (i_cmd.update) begin
                    r_have <= n_have;
                    r_best <= n_best;
                end
                if (r_out_valid && i_out_ready) begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_hit_found = r_out_hit;
    assign o_nearest_distance = r_out_dist;

endmodule
`default_nettype wire
